// File: design/rrmt_pkg.sv
// Shared types and constants for the register range map table.
`timescale 1ns / 1ps

package rrmt_pkg;

  localparam int unsigned RegionsPerKindDef = 8;
  localparam int unsigned TagBitsDef        = 8;
  localparam int unsigned KindCount         = 4;
  localparam int unsigned KindW             = 2;
  localparam int unsigned AddrW             = 16;
  localparam int unsigned PortTagW          = 8;
  localparam int unsigned IndexW            = 3;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StInvalid = 2'd1,
    StFull    = 2'd2
  } status_e;

  typedef enum logic {
    OpAdd    = 1'b0,
    OpLookup = 1'b1
  } op_e;

  // Control that travels with the token along the cell chain.
  typedef struct packed {
    logic valid;
    op_e  op;
    logic done;
    logic hit;
  } ctl_t;

endpackage

// File: design/rrmt_cell.sv
// One chain cell: holds one region slot of every kind and services the passing token.
`timescale 1ns / 1ps

module rrmt_cell #(
  parameter int unsigned IW = 3,
  parameter int unsigned FW = 4,
  parameter int unsigned TW = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rrmt_pkg::ctl_t              ctl_i,
  input  logic [rrmt_pkg::KindW-1:0]  kind_i,
  input  logic [rrmt_pkg::AddrW-1:0]  addr_i,
  input  logic [rrmt_pkg::AddrW-1:0]  end_i,
  input  logic [TW-1:0]               tag_i,
  input  logic [FW-1:0]               fill_i,
  input  logic [IW-1:0]               pos_i,
  output rrmt_pkg::ctl_t              ctl_o,
  output logic [rrmt_pkg::KindW-1:0]  kind_o,
  output logic [rrmt_pkg::AddrW-1:0]  addr_o,
  output logic [rrmt_pkg::AddrW-1:0]  end_o,
  output logic [TW-1:0]               tag_o,
  output logic [FW-1:0]               fill_o,
  output logic [IW-1:0]               pos_o
);
  import rrmt_pkg::*;

  logic [AddrW-1:0] start_q [KindCount];
  logic [AddrW-1:0] end_q   [KindCount];
  logic [TW-1:0]    tag_q   [KindCount];

  ctl_t             ctl_d, ctl_q;
  logic [TW-1:0]    tag_d, tag_q_out;
  logic [IW-1:0]    pos_d, pos_q;
  logic [KindW-1:0] kind_q;
  logic [AddrW-1:0] addr_q, endp_q;
  logic [FW-1:0]    fill_q;

  logic active, at_fill, match, wr_en;

  assign active  = ctl_i.valid && !ctl_i.done;
  // Token reaches the first unused slot: append point for an add, end of scan for a lookup.
  assign at_fill = (FW'(pos_i) == fill_i);
  assign match   = (addr_i >= start_q[kind_i]) && (addr_i <= end_q[kind_i]);
  assign wr_en   = active && at_fill && (ctl_i.op == OpAdd);

  always_comb begin
    ctl_d = ctl_i;
    tag_d = tag_i;
    if (active) begin
      if (at_fill) begin
        ctl_d.done = 1'b1;
      end else if (ctl_i.op == OpLookup && match) begin
        ctl_d.done = 1'b1;
        ctl_d.hit  = 1'b1;
        tag_d      = tag_q[kind_i];
      end
    end
    // Index freezes once the token is done.
    pos_d = ctl_d.done ? pos_i : IW'(pos_i + 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q    <= kind_i;
    addr_q    <= addr_i;
    endp_q    <= end_i;
    tag_q_out <= tag_d;
    fill_q    <= fill_i;
    pos_q     <= pos_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      start_q[kind_i] <= addr_i;
      end_q[kind_i]   <= end_i;
      tag_q[kind_i]   <= tag_i;
    end
  end

  assign ctl_o  = ctl_q;
  assign kind_o = kind_q;
  assign addr_o = addr_q;
  assign end_o  = endp_q;
  assign tag_o  = tag_q_out;
  assign fill_o = fill_q;
  assign pos_o  = pos_q;

endmodule

// File: design/register_range_map_table.sv
// Flow: a refused add reports in the cycle after the transfer; any other item walks the
// cell chain, one cell per cycle, through every cell register and then the result register.
// Occupancy: one item in flight; busy_o stays high from the launch of a chained item until
// its token leaves the chain end, so the chain length sets the rate.
// Reset: rst_ni clears fill counts and control; region slots hold nothing until written.
// Results are shown for one cycle on valid_o; the receiver cannot stall.
`timescale 1ns / 1ps

module register_range_map_table #(
  parameter int unsigned REGIONS_PER_KIND = rrmt_pkg::RegionsPerKindDef,
  parameter int unsigned TAG_BITS         = rrmt_pkg::TagBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic                           op_i,
  input  logic [rrmt_pkg::KindW-1:0]     reg_kind_i,
  input  logic [rrmt_pkg::AddrW-1:0]     address_i,
  input  logic [rrmt_pkg::AddrW-1:0]     reg_count_i,
  input  logic [rrmt_pkg::PortTagW-1:0]  handler_tag_i,
  output logic                           valid_o,
  output logic [1:0]                     status_o,
  output logic                           hit_o,
  output logic [rrmt_pkg::IndexW-1:0]    region_index_o,
  output logic [rrmt_pkg::PortTagW-1:0]  found_tag_o
);
  import rrmt_pkg::*;

  localparam int unsigned R  = REGIONS_PER_KIND;
  localparam int unsigned IW = (R > 1) ? $clog2(R) : 1;
  localparam int unsigned FW = $clog2(R + 1);
  localparam int unsigned TW = TAG_BITS;
  localparam logic [PortTagW-1:0] TagMask =
    (TAG_BITS >= PortTagW) ? {PortTagW{1'b1}} : PortTagW'((1 << TAG_BITS) - 1);

  ctl_t             ctl_c  [R+1];
  logic [KindW-1:0] kind_c [R+1];
  logic [AddrW-1:0] addr_c [R+1];
  logic [AddrW-1:0] end_c  [R+1];
  logic [TW-1:0]    tag_c  [R+1];
  logic [FW-1:0]    fill_c [R+1];
  logic [IW-1:0]    pos_c  [R+1];

  logic [FW-1:0]   fill_q [KindCount];
  logic            busy_q;
  logic            valid_q, hit_q;
  status_e         status_q;
  logic [IndexW-1:0]   index_q;
  logic [PortTagW-1:0] found_q;

  logic                accept, is_add, bad_arg, full, refused, launch;
  logic [PortTagW-1:0] tag_masked;
  logic [FW-1:0]       fill_sel;

  assign accept     = start_i && !busy_q;
  assign is_add     = (op_e'(op_i) == OpAdd);
  assign tag_masked = handler_tag_i & TagMask;
  assign fill_sel   = fill_q[reg_kind_i];
  assign bad_arg    = (address_i == '0) || (reg_count_i == '0) || (tag_masked == '0);
  assign full       = (fill_sel >= FW'(R));
  assign refused    = is_add && (bad_arg || full);
  assign launch     = accept && !refused;

  // Chain head.
  assign ctl_c[0]  = '{valid: launch, op: op_e'(op_i), done: 1'b0, hit: 1'b0};
  assign kind_c[0] = reg_kind_i;
  assign addr_c[0] = address_i;
  assign end_c[0]  = AddrW'(address_i + reg_count_i - 1'b1);
  assign tag_c[0]  = TW'(tag_masked);
  assign fill_c[0] = fill_sel;
  assign pos_c[0]  = '0;

  for (genvar i = 0; i < R; i++) begin : g_cell
    rrmt_cell #(
      .IW(IW),
      .FW(FW),
      .TW(TW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl_c[i]),
      .kind_i (kind_c[i]),
      .addr_i (addr_c[i]),
      .end_i  (end_c[i]),
      .tag_i  (tag_c[i]),
      .fill_i (fill_c[i]),
      .pos_i  (pos_c[i]),
      .ctl_o  (ctl_c[i+1]),
      .kind_o (kind_c[i+1]),
      .addr_o (addr_c[i+1]),
      .end_o  (end_c[i+1]),
      .tag_o  (tag_c[i+1]),
      .fill_o (fill_c[i+1]),
      .pos_o  (pos_c[i+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      valid_q <= 1'b0;
      for (int k = 0; k < KindCount; k++) begin
        fill_q[k] <= '0;
      end
    end else begin
      if (launch) begin
        busy_q <= 1'b1;
        if (is_add) begin
          fill_q[reg_kind_i] <= FW'(fill_sel + 1'b1);
        end
      end else if (ctl_c[R].valid) begin
        busy_q <= 1'b0;
      end
      valid_q <= (accept && refused) || ctl_c[R].valid;
    end
  end

  // Result payload; a token still not done at the chain end is a lookup miss.
  always_ff @(posedge clk_i) begin
    if (accept && refused) begin
      status_q <= bad_arg ? StInvalid : StFull;
      hit_q    <= 1'b0;
      index_q  <= '0;
      found_q  <= '0;
    end else if (ctl_c[R].valid) begin
      status_q <= StOk;
      hit_q    <= ctl_c[R].hit;
      if (ctl_c[R].hit) begin
        index_q <= IndexW'(pos_c[R]);
        found_q <= PortTagW'(tag_c[R]);
      end else if (ctl_c[R].op == OpAdd) begin
        index_q <= IndexW'(pos_c[R]);
        found_q <= '0;
      end else begin
        index_q <= '0;
        found_q <= '0;
      end
    end
  end

  assign busy_o         = busy_q;
  assign valid_o        = valid_q;
  assign status_o       = status_q;
  assign hit_o          = hit_q;
  assign region_index_o = index_q;
  assign found_tag_o    = found_q;

  logic [R-1:0] tok_valid;
  for (genvar j = 0; j < R; j++) begin : g_tok
    assign tok_valid[j] = ctl_c[j+1].valid;
  end

  a_one_token : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_valid))
    else $error("more than one token in the cell chain");

  a_token_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_valid != '0) |-> busy_q)
    else $error("token in chain while not busy");

  a_refused_reports : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && refused) |=> (valid_o && status_o != StOk && !hit_o))
    else $error("refused add did not report next cycle");

  a_hit_tag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && hit_o) |-> (found_tag_o != '0 && status_o == StOk))
    else $error("lookup hit with empty tag");

endmodule
